// ----- design/fra_pkg.sv -----
// fra_pkg: shared types for the fraction add and reduce block
// beat payload structs and the divider request/response structs
// no dependencies
`default_nettype none

package fra_pkg;

  localparam int unsigned InW   = 32;
  localparam int unsigned WideW = 64;

  // one input beat: two signed fractions
  typedef struct packed {
    logic signed [InW-1:0] num_a;
    logic signed [InW-1:0] den_a;
    logic signed [InW-1:0] num_b;
    logic signed [InW-1:0] den_b;
  } in_t;

  // one result beat: reduced sum and error flag
  typedef struct packed {
    logic signed [WideW-1:0] sum_num;
    logic [WideW-2:0]        sum_den;
    logic                    zero_gcd_error;
  } out_t;

  // request to the shared divider
  typedef struct packed {
    logic             start;
    logic [WideW-1:0] dividend;
    logic [WideW-1:0] divisor;
  } div_req_t;

  // response from the shared divider
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [WideW-1:0] quotient;
    logic [WideW-1:0] remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- design/fra_div.sv -----
// fra_div: 64-bit unsigned restoring divider, one quotient bit per cycle
// gives quotient and remainder; depends on fra_pkg
`default_nettype none

module fra_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire fra_pkg::div_req_t req_i,
  output fra_pkg::div_rsp_t      rsp_o
);

  localparam int unsigned W  = fra_pkg::WideW;
  localparam int unsigned CW = $clog2(W);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  dvs_q, dvs_d;

  logic [W:0]    shifted;
  logic [W+1:0]  diff;

  // partial remainder shift and trial subtract
  assign shifted = {rem_q, quo_q[W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

  // iteration control
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (busy_q) begin
      if (!diff[W+1]) begin
        rem_d = diff[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

  // done is a single-cycle pulse
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("divider done held longer than one cycle");

  // done follows the last iteration
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("divider done without a finished run");

  // remainder stays below the divisor while running
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && cnt_q != '0 |-> rem_q < dvs_q)
    else $error("divider partial remainder out of range");

endmodule

`default_nettype wire

// ----- design/fraction_add_reduce.sv -----
// fraction_add_reduce: a/b + c/d reduced by gcd, one shared divider for all steps
// k Euclid steps (k at most about 92) come before the two reductions; a zero gcd ends
// the beat without them; each divide is 64 bit-steps on the shared divider in fra_div
// one beat at a time: busy is high from accept until the result strobe cycle, and a
// new beat can be taken in that cycle; results cannot be stalled by the receiver
// reset clears the sequencer and strobes; no beat in flight; depends on fra_pkg, fra_div
`default_nettype none

module fraction_add_reduce (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start,
  output logic              busy,
  input  wire fra_pkg::in_t in_i,
  output logic              done_o,
  output fra_pkg::out_t     out_o
);

  localparam int unsigned W  = fra_pkg::WideW;
  localparam int unsigned IW = fra_pkg::InW;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL1  = 4'd1;
  localparam logic [3:0] ST_MUL2  = 4'd2;
  localparam logic [3:0] ST_MUL3  = 4'd3;
  localparam logic [3:0] ST_SUM   = 4'd4;
  localparam logic [3:0] ST_GCD   = 4'd5;
  localparam logic [3:0] ST_GWAIT = 4'd6;
  localparam logic [3:0] ST_DIVN  = 4'd7;
  localparam logic [3:0] ST_NWAIT = 4'd8;
  localparam logic [3:0] ST_DIVD  = 4'd9;
  localparam logic [3:0] ST_DWAIT = 4'd10;

  function automatic logic [IW-1:0] mag32(input logic signed [IW-1:0] x);
    logic [IW-1:0] m;
    m = x[IW-1] ? IW'(-x) : IW'(x);
    return m;
  endfunction

  logic [3:0]    state_q, state_d;
  logic          done_q, done_d;
  logic [IW-1:0] mna_q, mna_d, mda_q, mda_d, mnb_q, mnb_d, mdb_q, mdb_d;
  logic          sna_q, sna_d, sda_q, sda_d, snb_q, snb_d, sdb_q, sdb_d;
  logic [W-1:0]  m1_q, m1_d, m2_q, m2_d;
  logic [W-1:0]  nmag_q, nmag_d, dmag_q, dmag_d;
  logic [W-1:0]  x_q, x_d, y_q, y_d;
  logic [W-1:0]  rn_q, rn_d;
  logic          nneg_q, nneg_d, dneg_q, dneg_d;
  fra_pkg::out_t out_q, out_d;

  logic [IW-1:0] mul_a, mul_b;
  logic [W-1:0]  prod;
  logic          s1, s2, neg;
  logic [W-1:0]  nsum;
  logic          nsgn;

  fra_pkg::div_req_t div_req;
  fra_pkg::div_rsp_t div_rsp;

  fra_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // shared 32x32 multiplier operand select
  always_comb begin
    unique case (state_q)
      ST_MUL1: begin mul_a = mna_q; mul_b = mdb_q; end
      ST_MUL2: begin mul_a = mnb_q; mul_b = mda_q; end
      default: begin mul_a = mda_q; mul_b = mdb_q; end
    endcase
  end
  assign prod = W'(mul_a) * W'(mul_b);

  // signed add of the cross products in sign-magnitude form
  always_comb begin
    s1 = (sna_q ^ sdb_q) && (m1_q != '0);
    s2 = (snb_q ^ sda_q) && (m2_q != '0);
    if (s1 == s2) begin
      nsum = m1_q + m2_q;
      nsgn = s1;
    end else if (m1_q >= m2_q) begin
      nsum = m1_q - m2_q;
      nsgn = s1;
    end else begin
      nsum = m2_q - m1_q;
      nsgn = s2;
    end
  end

  // divider request: Euclid remainder, then the two reductions by the gcd
  always_comb begin
    div_req.start    = ((state_q == ST_GCD) && (y_q != '0)) ||
                       (state_q == ST_DIVN) || (state_q == ST_DIVD);
    div_req.dividend = (state_q == ST_DIVN) ? nmag_q :
                       (state_q == ST_DIVD) ? dmag_q : x_q;
    div_req.divisor  = (state_q == ST_GCD) ? y_q : x_q;
  end

  // final sign of the reduced numerator
  assign neg = (nneg_q ^ dneg_q) && (rn_q != '0) && (dmag_q != '0);

  // sequencer
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    mna_d = mna_q; mda_d = mda_q; mnb_d = mnb_q; mdb_d = mdb_q;
    sna_d = sna_q; sda_d = sda_q; snb_d = snb_q; sdb_d = sdb_q;
    m1_d = m1_q; m2_d = m2_q; nmag_d = nmag_q; dmag_d = dmag_q;
    x_d = x_q; y_d = y_q; rn_d = rn_q;
    nneg_d = nneg_q; dneg_d = dneg_q;
    out_d = out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          mna_d = mag32(in_i.num_a); sna_d = in_i.num_a[IW-1];
          mda_d = mag32(in_i.den_a); sda_d = in_i.den_a[IW-1];
          mnb_d = mag32(in_i.num_b); snb_d = in_i.num_b[IW-1];
          mdb_d = mag32(in_i.den_b); sdb_d = in_i.den_b[IW-1];
          state_d = ST_MUL1;
        end
      end
      ST_MUL1: begin
        m1_d = prod;
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        m2_d = prod;
        state_d = ST_MUL3;
      end
      ST_MUL3: begin
        dmag_d = prod;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        nmag_d = nsum;
        nneg_d = nsgn;
        dneg_d = sda_q ^ sdb_q;
        x_d = nsum;
        y_d = dmag_q;
        state_d = ST_GCD;
      end
      ST_GCD: begin
        // y zero: gcd sits in x
        if (y_q != '0) begin
          state_d = ST_GWAIT;
        end else if (x_q == '0) begin
          out_d.sum_num        = '0;
          out_d.sum_den        = '0;
          out_d.zero_gcd_error = 1'b1;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_DIVN;
        end
      end
      ST_GWAIT: begin
        if (div_rsp.done) begin
          x_d = y_q;
          y_d = div_rsp.remainder;
          state_d = ST_GCD;
        end
      end
      ST_DIVN: begin
        state_d = ST_NWAIT;
      end
      ST_NWAIT: begin
        if (div_rsp.done) begin
          rn_d = div_rsp.quotient;
          state_d = ST_DIVD;
        end
      end
      ST_DIVD: begin
        state_d = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_rsp.done) begin
          out_d.sum_num        = neg ? -$signed(rn_q) : $signed(rn_q);
          out_d.sum_den        = div_rsp.quotient[W-2:0];
          out_d.zero_gcd_error = 1'b0;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    mna_q <= mna_d; mda_q <= mda_d; mnb_q <= mnb_d; mdb_q <= mdb_d;
    sna_q <= sna_d; sda_q <= sda_d; snb_q <= snb_d; sdb_q <= sdb_d;
    m1_q <= m1_d; m2_q <= m2_d; nmag_q <= nmag_d; dmag_q <= dmag_d;
    x_q <= x_d; y_q <= y_d; rn_q <= rn_d;
    nneg_q <= nneg_d; dneg_q <= dneg_d;
    out_q <= out_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign out_o  = out_q;

  // an accepted beat keeps the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted beat did not start the sequencer");

  // the result strobe frees the block
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy && $past(busy))
    else $error("result strobe while busy or without a beat");

  // error results are 0/0
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_o.zero_gcd_error |-> out_o.sum_num == '0 && out_o.sum_den == '0)
    else $error("zero gcd result not 0/0");

  // divider is only started when it is free
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while running");

endmodule

`default_nettype wire
